// ===== hw/rtl/pfl_pkg.sv =====
// Package for the physical memory / free frame list block.
// Holds operation codes, field types and fixed constants; no dependencies.
`default_nettype none
package pfl_pkg;

    typedef logic [2:0]  t_opcode;
    typedef logic [15:0] t_address;
    typedef logic [7:0]  t_byte;
    typedef logic [7:0]  t_frame;
    typedef logic [8:0]  t_frame_cnt;

    localparam t_opcode OP_READ   = 3'd0;
    localparam t_opcode OP_WRITE  = 3'd1;
    localparam t_opcode OP_GET    = 3'd2;
    localparam t_opcode OP_PUT    = 3'd3;
    localparam t_opcode OP_FORMAT = 3'd4;

    // format never makes more than this many frames free
    localparam t_frame_cnt MAX_FRAMES       = 9'd256;
    localparam t_frame_cnt FRAME_CNT_RESET  = 9'd256;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

endpackage
`default_nettype wire

// ===== hw/rtl/pfl_if.sv =====
// Valid/ready channels of the free frame list block: operation in, result out, config write.
// Depends on pfl_pkg.
`default_nettype none
interface pfl_in_if;
    import pfl_pkg::*;
    logic     valid;
    logic     ready;
    t_opcode  opcode;
    t_address address;
    t_byte    write_data;
    t_frame   frame_in;
    modport source (output valid, output opcode, output address, output write_data,
                    output frame_in, input ready);
    modport sink   (input valid, input opcode, input address, input write_data,
                    input frame_in, output ready);
endinterface

interface pfl_out_if;
    import pfl_pkg::*;
    logic   valid;
    logic   ready;
    t_byte  read_data;
    t_frame frame_out;
    logic   status;
    modport source (output valid, output read_data, output frame_out, output status,
                    input ready);
    modport sink   (input valid, input read_data, input frame_out, input status,
                    output ready);
endinterface

interface pfl_cfg_if;
    import pfl_pkg::*;
    logic       valid;
    logic       ready;
    t_frame_cnt data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pfl_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module pfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== hw/rtl/phys_memory_with_free_frame_list.sv =====
// Byte-wide physical memory with a LIFO pool of free page frames.
// Depends on pfl_pkg, pfl_if.sv (channels) and pfl_ram.
//
// Usage:
//   i_in  : one operation per item (read, write, get frame, put frame, format).
//   o_out : exactly one result item per operation, in order.
//   i_cfg : writes frame_count, used by the next format; always ready.
// Throughput is one item per cycle when not clearing and o_out is not stalled.
// An item passes the read stage and then the result register: the byte store and
// the frame stack each do their one access at the acceptance edge (registered read).
// All pool state (stack pointer, next unused frame, limit) is updated at the
// acceptance edge, so back-to-back operations see each other's effects.
// After reset the byte store is cleared by a pass over all MEM_BYTES addresses,
// one byte per cycle; i_in.ready stays low meanwhile.
// When the receiver stalls, the result register holds and one more item may
// sit in the memory read stage; i_in.ready then drops until o_out drains.
// MEM_BYTES must be a power of two; addresses wrap modulo MEM_BYTES.
`default_nettype none
module phys_memory_with_free_frame_list #(
    parameter int MEM_BYTES  = 65536,
    parameter int POOL_DEPTH = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pfl_in_if.sink    i_in,
    pfl_out_if.source o_out,
    pfl_cfg_if.sink   i_cfg
);
    import pfl_pkg::*;

    localparam int MAW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
    localparam int SAW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CW  = $clog2(POOL_DEPTH + 1);

    // configuration and pool state
    t_frame_cnt     r_frame_count;
    logic [CW-1:0]  r_ret_count, n_ret_count;
    t_frame_cnt     r_next_unused, n_next_unused;
    t_frame_cnt     r_limit, n_limit;

    // clearing pass
    logic           r_clearing;
    logic [MAW-1:0] r_clr_addr;

    // read stage
    logic           r_s1_valid;
    logic           r_s1_is_read;
    logic           r_s1_use_stack;
    t_frame         r_s1_frame;
    logic           r_s1_status;

    // result register
    logic           r_out_valid;
    t_byte          r_out_read_data;
    t_frame         r_out_frame;
    logic           r_out_status;

    logic           out_free, s1_advance, accept;
    logic           n_use_stack, n_status;
    t_frame         n_frame;

    logic [31:0]    addr_ext;
    logic           mem_en, mem_we;
    logic [MAW-1:0] mem_addr;
    t_byte          mem_wdata, mem_rdata;

    logic           stk_en, stk_we;
    logic [CW-1:0]  cnt_m1;
    logic [SAW-1:0] stk_addr;
    t_frame         stk_rdata;

    logic           pool_full, stack_nonempty;

    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_advance = r_s1_valid && out_free;
    assign i_in.ready = !r_clearing && (!r_s1_valid || out_free);
    assign accept     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign pool_full      = (r_ret_count == CW'(POOL_DEPTH));
    assign stack_nonempty = (r_ret_count != '0);
    assign cnt_m1         = r_ret_count - 1'b1;

    // byte store port: clearing pass, or one read/write per accepted item
    assign addr_ext = {16'd0, i_in.address};
    always_comb begin
        if (r_clearing) begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_en    = accept && (i_in.opcode == OP_READ || i_in.opcode == OP_WRITE);
            mem_we    = (i_in.opcode == OP_WRITE);
            mem_addr  = addr_ext[MAW-1:0];
            mem_wdata = i_in.write_data;
        end
    end

    pfl_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES),
        .AW    (MAW)
    ) u_byte_store (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // pool update for the item being accepted
    always_comb begin
        n_ret_count   = r_ret_count;
        n_next_unused = r_next_unused;
        n_limit       = r_limit;
        n_use_stack   = 1'b0;
        n_frame       = '0;
        n_status      = STATUS_OK;
        stk_en        = 1'b0;
        stk_we        = 1'b0;
        stk_addr      = r_ret_count[SAW-1:0];
        case (i_in.opcode)
            OP_READ, OP_WRITE: begin
            end
            OP_GET: begin
                if (stack_nonempty) begin
                    // returned frames go out first, last in first out
                    n_ret_count = cnt_m1;
                    n_use_stack = 1'b1;
                    stk_en      = 1'b1;
                    stk_addr    = cnt_m1[SAW-1:0];
                end else if (r_next_unused < r_limit) begin
                    n_frame       = r_next_unused[7:0];
                    n_next_unused = r_next_unused + 1'b1;
                end else begin
                    n_status = STATUS_FAIL;
                end
            end
            OP_PUT: begin
                if (pool_full) begin
                    n_status = STATUS_FAIL;
                end else begin
                    n_ret_count = r_ret_count + 1'b1;
                    stk_en      = 1'b1;
                    stk_we      = 1'b1;
                end
            end
            OP_FORMAT: begin
                if (r_frame_count == '0) begin
                    n_status = STATUS_FAIL;
                end else begin
                    n_ret_count   = '0;
                    n_next_unused = '0;
                    n_limit       = (r_frame_count > MAX_FRAMES) ? MAX_FRAMES : r_frame_count;
                end
            end
            default: begin
                n_status = STATUS_FAIL;
            end
        endcase
        stk_en = stk_en && accept;
    end

    pfl_ram #(
        .WIDTH (8),
        .DEPTH (POOL_DEPTH),
        .AW    (SAW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_en    (stk_en),
        .i_we    (stk_we),
        .i_addr  (stk_addr),
        .i_wdata (i_in.frame_in),
        .o_rdata (stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FRAME_CNT_RESET;
            r_ret_count   <= '0;
            r_next_unused <= '0;
            r_limit       <= MAX_FRAMES;
            r_clearing    <= 1'b1;
            r_clr_addr    <= '0;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_frame_count <= i_cfg.data;
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clearing <= 1'b0;
                end
            end
            if (accept) begin
                r_ret_count   <= n_ret_count;
                r_next_unused <= n_next_unused;
                r_limit       <= n_limit;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_is_read   <= (i_in.opcode == OP_READ);
            r_s1_use_stack <= n_use_stack;
            r_s1_frame     <= n_frame;
            r_s1_status    <= n_status;
        end
        if (s1_advance) begin
            r_out_read_data <= r_s1_is_read ? mem_rdata : '0;
            r_out_frame     <= r_s1_use_stack ? stk_rdata : r_s1_frame;
            r_out_status    <= r_s1_status;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_out_read_data;
    assign o_out.frame_out = r_out_frame;
    assign o_out.status    = r_out_status;

endmodule
`default_nettype wire
